FILE: sv/wmfb_pkg.sv
`timescale 1ns / 1ps

package wmfb_pkg;

    // Frame kinds held in the kind register
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_MGMT = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_KIND     = 3'd0;
    localparam logic [2:0] REG_DURATION = 3'd1;
    localparam logic [2:0] REG_DEST     = 3'd2;
    localparam logic [2:0] REG_SOURCE   = 3'd3;
    localparam logic [2:0] REG_BSS      = 3'd4;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 48;

    // Payload limit per message
    localparam logic [10:0] MAX_PAYLOAD = 11'd1500;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Frame control low bytes
    localparam logic [7:0] FC_DATA = 8'h08;
    localparam logic [7:0] FC_ACK  = 8'hD4;

    // Byte positions inside the header walk
    localparam logic [4:0] POS_FC_HI     = 5'd1;
    localparam logic [4:0] POS_DUR_LO    = 5'd2;
    localparam logic [4:0] POS_DUR_HI    = 5'd3;
    localparam logic [4:0] POS_DEST      = 5'd4;
    localparam logic [4:0] POS_SOURCE    = 5'd10;
    localparam logic [4:0] POS_BSS       = 5'd16;
    localparam logic [4:0] POS_SEQ_LO    = 5'd22;
    localparam logic [4:0] HDR_LAST      = 5'd23;
    localparam logic [4:0] ACK_FCS_START = 5'd10;
    localparam logic [4:0] ACK_LAST      = 5'd13;
    localparam logic [4:0] FCS_LAST      = 5'd3;

    // Outstanding parts of the item being sent
    typedef struct packed {
        logic hdr;
        logic pay;
        logic fcs;
        logic ack;
    } pend_t;

    // Advance the CRC by one byte, one bit per step
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Address byte k, most significant byte first
    function automatic logic [7:0] addr_byte(input logic [47:0] addr, input logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0:    b = addr[47:40];
            3'd1:    b = addr[39:32];
            3'd2:    b = addr[31:24];
            3'd3:    b = addr[23:16];
            3'd4:    b = addr[15:8];
            3'd5:    b = addr[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // FCS byte k, least significant byte first
    function automatic logic [7:0] fcs_byte(input logic [31:0] crc, input logic [1:0] k);
        logic [31:0] f;
        logic [7:0]  b;
        f = ~crc;
        unique case (k)
            2'd0:    b = f[7:0];
            2'd1:    b = f[15:8];
            2'd2:    b = f[23:16];
            default: b = f[31:24];
        endcase
        return b;
    endfunction

    // Header byte at position pos (data header, or the ack prefix)
    function automatic logic [7:0] hdr_byte(
        input logic [4:0]  pos,
        input logic        ack,
        input logic [15:0] dur,
        input logic [47:0] dest,
        input logic [47:0] src,
        input logic [47:0] bss,
        input logic [11:0] seq
    );
        logic [15:0] sc;
        logic [7:0]  b;
        sc = {seq, 4'd0};
        if (pos < POS_FC_HI) begin
            b = ack ? FC_ACK : FC_DATA;
        end
        else if (pos < POS_DUR_LO) begin
            b = 8'd0;
        end
        else if (pos < POS_DUR_HI) begin
            b = dur[7:0];
        end
        else if (pos < POS_DEST) begin
            b = dur[15:8];
        end
        else if (pos < POS_SOURCE) begin
            b = addr_byte(dest, 3'(pos - POS_DEST));
        end
        else if (pos < POS_BSS) begin
            b = addr_byte(src, 3'(pos - POS_SOURCE));
        end
        else if (pos < POS_SEQ_LO) begin
            b = addr_byte(bss, 3'(pos - POS_BSS));
        end
        else if (pos < HDR_LAST) begin
            b = sc[7:0];
        end
        else begin
            b = sc[15:8];
        end
        return b;
    endfunction

endpackage

FILE: sv/wlan_mac_frame_builder_unit.sv
`timescale 1ns / 1ps

// 802.11 MAC frame builder. Payload bytes of a message enter on the slave stream with
// first (tuser[1]) and last (tlast) marks; built frame bytes leave on the master stream,
// one byte per transaction, with tlast on the final FCS byte and tuser set there when
// payload beyond 1500 bytes was dropped. In data mode the first item brings a 24-byte
// header, each kept payload byte passes through and the last item appends the CRC-32
// FCS; in ack mode the last item brings a 14-byte ack frame; management mode sends
// nothing. The FCS is 4 bytes. A new input item is taken only once the current item puts
// out its final byte, and an item that causes no bytes does not hold back the next one;
// output stalls hold items back further. A single byte-wide output register carries
// every byte, and the CRC advances by one byte with each header or payload byte sent.
// Write configuration only while the block is idle.
module wlan_mac_frame_builder_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [wmfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wmfb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] payload_byte
    input  logic [1:0]                         s_tuser,   // [0] has_byte, [1] first_item
    input  logic                               s_tlast,   // last_item
    // Output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic                               m_tuser,   // [0] too_long
    output logic                               m_tlast    // frame_end
);

    // Configuration registers
    logic [1:0]  kind_reg;
    logic [15:0] dur_reg;
    logic [47:0] dest_reg;
    logic [47:0] src_reg;
    logic [47:0] bss_reg;

    // Frame state
    logic [11:0] seq_reg, seq_next;
    logic [31:0] crc_reg, crc_next, crc_em;
    logic [31:0] ack_crc_reg, ack_crc_next, ack_crc_em;
    logic [10:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic        in_frame_reg, in_frame_next;

    // Item being sent
    wmfb_pkg::pend_t pend_reg, pend_next, pend_em, plan;
    logic [4:0]  idx_reg, idx_next, idx_em;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [11:0] seq_item_reg, seq_item_next;
    logic        flag_reg, flag_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;
    logic        m_user_reg, m_user_next;

    logic        busy;
    logic        emit;
    logic        accept;
    logic [7:0]  hbyte;
    logic        in_has;
    logic        in_first;
    logic [10:0] acc_count;
    logic        acc_ovf;
    logic        acc_in_frame;
    logic        acc_keep;

    assign in_has   = s_tuser[0];
    assign in_first = s_tuser[1];

    assign busy   = pend_reg.hdr | pend_reg.pay | pend_reg.fcs | pend_reg.ack;
    assign emit   = busy && (!m_valid_reg || m_tready);
    assign hbyte  = wmfb_pkg::hdr_byte(idx_reg, pend_reg.ack, dur_reg, dest_reg, src_reg,
                                       bss_reg, seq_item_reg);

    // Take a new item once the current one puts out its final byte
    assign s_tready = !(pend_em.hdr | pend_em.pay | pend_em.fcs | pend_em.ack);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Send one byte of the current item
    always_comb
    begin
        pend_em      = pend_reg;
        idx_em       = idx_reg;
        crc_em       = crc_reg;
        ack_crc_em   = ack_crc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_last_next  = 1'b0;
            m_user_next  = 1'b0;
            priority if (pend_reg.ack)
            begin
                if (idx_reg < wmfb_pkg::ACK_FCS_START)
                begin
                    m_data_next = hbyte;
                    ack_crc_em  = wmfb_pkg::crc_feed(ack_crc_reg, hbyte);
                end
                else
                begin
                    m_data_next = wmfb_pkg::fcs_byte(ack_crc_reg,
                                                     2'(idx_reg - wmfb_pkg::ACK_FCS_START));
                end
                if (idx_reg == wmfb_pkg::ACK_LAST)
                begin
                    pend_em.ack = 1'b0;
                    idx_em      = 5'd0;
                    m_last_next = 1'b1;
                    m_user_next = flag_reg;
                end
                else
                begin
                    idx_em = idx_reg + 5'd1;
                end
            end
            else if (pend_reg.hdr)
            begin
                m_data_next = hbyte;
                crc_em      = wmfb_pkg::crc_feed(crc_reg, hbyte);
                if (idx_reg == wmfb_pkg::HDR_LAST)
                begin
                    pend_em.hdr = 1'b0;
                    idx_em      = 5'd0;
                end
                else
                begin
                    idx_em = idx_reg + 5'd1;
                end
            end
            else if (pend_reg.pay)
            begin
                m_data_next = pbyte_reg;
                crc_em      = wmfb_pkg::crc_feed(crc_reg, pbyte_reg);
                pend_em.pay = 1'b0;
            end
            else
            begin
                m_data_next = wmfb_pkg::fcs_byte(crc_reg, idx_reg[1:0]);
                if (idx_reg == wmfb_pkg::FCS_LAST)
                begin
                    pend_em.fcs = 1'b0;
                    idx_em      = 5'd0;
                    crc_em      = wmfb_pkg::CRC_INIT;
                    m_last_next = 1'b1;
                    m_user_next = flag_reg;
                end
                else
                begin
                    idx_em = idx_reg + 5'd1;
                end
            end
        end
    end

    // Decide what a newly taken item sends and update the message state
    always_comb
    begin
        pend_next     = pend_em;
        idx_next      = idx_em;
        crc_next      = crc_em;
        ack_crc_next  = ack_crc_em;
        seq_next      = seq_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        in_frame_next = in_frame_reg;
        pbyte_next    = pbyte_reg;
        seq_item_next = seq_item_reg;
        flag_next     = flag_reg;
        acc_count     = count_reg;
        acc_ovf       = ovf_reg;
        acc_in_frame  = in_frame_reg;
        acc_keep      = 1'b0;
        plan          = '0;
        if (accept)
        begin
            // Restart the message on a first mark
            if (in_first)
            begin
                acc_count    = 11'd0;
                acc_ovf      = 1'b0;
                acc_in_frame = 1'b0;
                crc_next     = wmfb_pkg::CRC_INIT;
            end
            // Count the byte, drop it beyond the limit
            if (in_has)
            begin
                if (acc_count < wmfb_pkg::MAX_PAYLOAD)
                begin
                    acc_count = acc_count + 11'd1;
                    acc_keep  = 1'b1;
                end
                else
                begin
                    acc_ovf = 1'b1;
                end
            end
            if (kind_reg == wmfb_pkg::KIND_DATA)
            begin
                if (in_first)
                begin
                    seq_item_next = seq_reg;
                    seq_next      = seq_reg + 12'd1;
                    acc_in_frame  = 1'b1;
                    plan.hdr      = 1'b1;
                end
                plan.pay = acc_in_frame && acc_keep;
                if (acc_in_frame && s_tlast)
                begin
                    plan.fcs     = 1'b1;
                    acc_in_frame = 1'b0;
                end
            end
            else if (kind_reg == wmfb_pkg::KIND_ACK)
            begin
                if (s_tlast)
                begin
                    plan.ack     = 1'b1;
                    acc_in_frame = 1'b0;
                    ack_crc_next = wmfb_pkg::CRC_INIT;
                end
            end
            else
            begin
                if (s_tlast)
                begin
                    acc_in_frame = 1'b0;
                end
            end
            pend_next     = plan;
            idx_next      = 5'd0;
            pbyte_next    = s_tdata;
            flag_next     = acc_ovf;
            count_next    = acc_count;
            ovf_next      = acc_ovf;
            in_frame_next = acc_in_frame;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= wmfb_pkg::KIND_DATA;
            dur_reg  <= '0;
            dest_reg <= '0;
            src_reg  <= '0;
            bss_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wmfb_pkg::REG_KIND:     kind_reg <= cfg_data[1:0];
                wmfb_pkg::REG_DURATION: dur_reg  <= cfg_data[15:0];
                wmfb_pkg::REG_DEST:     dest_reg <= cfg_data;
                wmfb_pkg::REG_SOURCE:   src_reg  <= cfg_data;
                wmfb_pkg::REG_BSS:      bss_reg  <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= '0;
            crc_reg      <= wmfb_pkg::CRC_INIT;
            ack_crc_reg  <= wmfb_pkg::CRC_INIT;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            in_frame_reg <= 1'b0;
            pend_reg     <= '0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            seq_reg      <= seq_next;
            crc_reg      <= crc_next;
            ack_crc_reg  <= ack_crc_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            in_frame_reg <= in_frame_next;
            pend_reg     <= pend_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Registers without reset: payload, item state and output data
    always_ff @(posedge clk)
    begin
        pbyte_reg    <= pbyte_next;
        seq_item_reg <= seq_item_next;
        flag_reg     <= flag_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_user_reg   <= m_user_next;
    end

endmodule

FILE: tb/sv/tb_wlan_mac_frame_builder_unit.sv
`timescale 1ns / 1ps

module tb_wlan_mac_frame_builder_unit;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 6;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned IDLE_PCT      = 9;
    localparam int unsigned MAX_SHOWN     = 10;
    localparam int unsigned IDX_W         = wmfb_pkg::CFG_INDEX_W;
    localparam int unsigned DATA_W        = wmfb_pkg::CFG_DATA_W;
    localparam logic [1:0]  KIND_RSVD     = 2'd3;
    localparam logic [47:0] ADDR_ONES     = 48'hFFFF_FFFF_FFFF;

    // One input message item and one built frame byte
    typedef struct packed {
        logic [7:0] payload;
        logic       has_byte;
        logic       first_mark;
        logic       last_mark;
        logic       hold_off;
    } msg_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       too_long;
    } frame_byte_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    // Predictor copy of the configuration
    logic [1:0]  cfg_kind     = wmfb_pkg::KIND_DATA;
    logic [15:0] cfg_duration = '0;
    logic [47:0] cfg_dest     = '0;
    logic [47:0] cfg_source   = '0;
    logic [47:0] cfg_bss      = '0;

    // Predictor copy of the frame state
    logic [11:0] seq_num    = '0;
    logic [31:0] fcs_crc    = wmfb_pkg::CRC_INIT;
    logic [10:0] pay_count  = '0;
    logic        drop_flag  = 1'b0;
    logic        frame_open = 1'b0;

    msg_item_t   pending_items[$];
    msg_item_t   held_item;
    frame_byte_t expected_bytes[$];
    frame_byte_t want;

    logic quiet_mode     = 1'b0;
    int   cycle_count    = 0;
    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   bytes_checked  = 0;
    int   frames_seen    = 0;

    wlan_mac_frame_builder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // Reflected CRC-32, one bit per step
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ wmfb_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic emit_byte(input logic [7:0] b, inout logic [31:0] crc);
        crc = crc32_step(crc, b);
        expected_bytes.push_back('{b, 1'b0, 1'b0});
    endtask

    // Address goes out most significant byte first
    task automatic emit_addr(input logic [47:0] addr, inout logic [31:0] crc);
        for (int s = 5; s >= 0; s--)
            emit_byte(addr[8*s +: 8], crc);
    endtask

    // FCS goes out least significant byte first, marks on the final byte
    task automatic emit_fcs(input logic [31:0] crc, input logic flag);
        logic [31:0] fcs;
        fcs = ~crc;
        for (int i = 0; i < 4; i++)
            expected_bytes.push_back('{fcs[8*i +: 8], (i == 3), (i == 3) & flag});
    endtask

    // Work out the frame bytes that one accepted item brings out
    task automatic predict_frame_bytes(input msg_item_t it);
        logic        keep;
        logic [15:0] seq_ctl;
        logic [31:0] ack_crc;
        keep = 1'b0;
        if (it.first_mark) begin
            pay_count  = '0;
            drop_flag  = 1'b0;
            fcs_crc    = wmfb_pkg::CRC_INIT;
            frame_open = 1'b0;
        end
        if (it.has_byte) begin
            if (pay_count < wmfb_pkg::MAX_PAYLOAD) begin
                pay_count = pay_count + 11'd1;
                keep      = 1'b1;
            end
            else begin
                drop_flag = 1'b1;
            end
        end
        if (cfg_kind == wmfb_pkg::KIND_DATA) begin
            if (it.first_mark) begin
                seq_ctl = {seq_num, 4'd0};
                emit_byte(wmfb_pkg::FC_DATA, fcs_crc);
                emit_byte(8'h00, fcs_crc);
                emit_byte(cfg_duration[7:0], fcs_crc);
                emit_byte(cfg_duration[15:8], fcs_crc);
                emit_addr(cfg_dest, fcs_crc);
                emit_addr(cfg_source, fcs_crc);
                emit_addr(cfg_bss, fcs_crc);
                emit_byte(seq_ctl[7:0], fcs_crc);
                emit_byte(seq_ctl[15:8], fcs_crc);
                seq_num    = seq_num + 12'd1;
                frame_open = 1'b1;
            end
            if (frame_open && keep)
                emit_byte(it.payload, fcs_crc);
            if (frame_open && it.last_mark) begin
                emit_fcs(fcs_crc, drop_flag);
                fcs_crc    = wmfb_pkg::CRC_INIT;
                frame_open = 1'b0;
            end
        end
        else if (cfg_kind == wmfb_pkg::KIND_ACK) begin
            if (it.last_mark) begin
                ack_crc = wmfb_pkg::CRC_INIT;
                emit_byte(wmfb_pkg::FC_ACK, ack_crc);
                emit_byte(8'h00, ack_crc);
                emit_byte(cfg_duration[7:0], ack_crc);
                emit_byte(cfg_duration[15:8], ack_crc);
                emit_addr(cfg_dest, ack_crc);
                emit_fcs(ack_crc, drop_flag);
                frame_open = 1'b0;
            end
        end
        else if (it.last_mark) begin
            frame_open = 1'b0;
        end
    endtask

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%s", msg);
    endtask

    // Input driver: present queued items, idle at random
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                predict_frame_bytes(held_item);
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 &&
                    !(pending_items[0].hold_off && expected_bytes.size() != 0) &&
                    (quiet_mode || $urandom_range(99) >= IDLE_PCT)) begin
                    held_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= held_item.payload;
                    s_tuser  <= {held_item.first_mark, held_item.has_byte};
                    s_tlast  <= held_item.last_mark;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: stall at random, check each transaction against the oldest expectation
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
            if (m_tvalid && m_tready) begin
                bytes_checked++;
                if (m_tlast)
                    frames_seen++;
                if (expected_bytes.size() == 0) begin
                    report_error($sformatf("unexpected byte %02h end %0b too_long %0b",
                                           m_tdata, m_tlast, m_tuser));
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.frame_end ||
                        m_tuser !== want.too_long)
                        report_error($sformatf(
                            {"byte %0d: expected %02h end %0b too_long %0b, ",
                             "got %02h end %0b too_long %0b"},
                            bytes_checked, want.data, want.frame_end, want.too_long,
                            m_tdata, m_tlast, m_tuser));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            wmfb_pkg::REG_KIND:     cfg_kind     = value[1:0];
            wmfb_pkg::REG_DURATION: cfg_duration = value[15:0];
            wmfb_pkg::REG_DEST:     cfg_dest     = value[47:0];
            wmfb_pkg::REG_SOURCE:   cfg_source   = value[47:0];
            wmfb_pkg::REG_BSS:      cfg_bss      = value[47:0];
            default:                ;
        endcase
    endtask

    task automatic set_frame_regs(input logic [1:0] kind, input logic [15:0] dur,
                                  input logic [47:0] dest, input logic [47:0] src,
                                  input logic [47:0] bss);
        write_reg(wmfb_pkg::REG_KIND, DATA_W'(kind));
        write_reg(wmfb_pkg::REG_DURATION, DATA_W'(dur));
        write_reg(wmfb_pkg::REG_DEST, dest);
        write_reg(wmfb_pkg::REG_SOURCE, src);
        write_reg(wmfb_pkg::REG_BSS, bss);
    endtask

    function automatic logic [47:0] rand_addr();
        return {16'($urandom), $urandom};
    endfunction

    task automatic add_item(input logic [7:0] p, input logic has, input logic first_m,
                            input logic last_m, input logic hold);
        pending_items.push_back('{p, has, first_m, last_m, hold});
    endtask

    // Well-formed message of len bytes; len 0 is an empty message
    task automatic queue_message(input int len, input logic hold);
        if (len == 0) begin
            add_item(8'($urandom), 1'b0, 1'b1, 1'b1, hold);
        end
        else begin
            for (int k = 0; k < len; k++)
                add_item(8'($urandom), 1'b1, (k == 0), (k == len - 1), hold && (k == 0));
        end
    endtask

    // Mostly well-formed messages, some noise and some messages left open
    task automatic queue_random_traffic(input int n_items);
        int added;
        int len;
        int pick;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                len = $urandom_range(0, 6);
                queue_message(len, ($urandom_range(99) < 5));
                added += (len == 0) ? 1 : len;
            end
            else if (pick < 87) begin
                add_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'b0);
            end
            else begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    add_item(8'($urandom), 1'($urandom_range(9) != 0), (k == 0), 1'b0, 1'b0);
                added += len;
            end
        end
    endtask

    // Wait until every item is taken and every byte has come, then let the block settle
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input logic [1:0] kind, input logic [15:0] dur,
                                    input logic [47:0] dest, input logic [47:0] src,
                                    input logic [47:0] bss, input int n_items);
        set_frame_regs(kind, dur, dest, src, bss);
        queue_random_traffic(n_items / 2);
        // hold the sender until the frame so far is out
        queue_message(3, 1'b1);
        queue_random_traffic(n_items - n_items / 2);
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Data frames, all-zero header fields
        set_frame_regs(wmfb_pkg::KIND_DATA, 16'h0000, '0, '0, '0);
        add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'hA5, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
        // stray items outside a frame
        add_item(8'h5A, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'h3C, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        // restart inside an open frame, then an item without a byte
        add_item(8'h11, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h22, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'h33, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(8'h44, 1'b1, 1'b0, 1'b1, 1'b0);
        drain();

        // All-ones header fields; leave a frame open and close it in ack mode
        set_frame_regs(wmfb_pkg::KIND_DATA, 16'hFFFF, ADDR_ONES, ADDR_ONES, ADDR_ONES);
        add_item(8'hC3, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h7E, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(8'h81, 1'b1, 1'b1, 1'b0, 1'b0);
        drain();
        write_reg(wmfb_pkg::REG_KIND, DATA_W'(wmfb_pkg::KIND_ACK));
        add_item(8'h18, 1'b1, 1'b0, 1'b1, 1'b0);
        drain();
        write_reg(wmfb_pkg::REG_KIND, DATA_W'(wmfb_pkg::KIND_DATA));
        add_item(8'h99, 1'b1, 1'b0, 1'b0, 1'b0);
        drain();

        // Ack frames: a full message, a first without last, a lone last
        set_frame_regs(wmfb_pkg::KIND_ACK, 16'($urandom), rand_addr(), rand_addr(),
                       rand_addr());
        add_item(8'h12, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h34, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(8'h56, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        drain();

        // Management and reserved kinds, one of them closing an open data frame
        write_reg(wmfb_pkg::REG_KIND, DATA_W'(wmfb_pkg::KIND_DATA));
        add_item(8'h0F, 1'b1, 1'b1, 1'b0, 1'b0);
        drain();
        write_reg(wmfb_pkg::REG_KIND, DATA_W'(wmfb_pkg::KIND_MGMT));
        add_item(8'hF0, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(8'hAA, 1'b1, 1'b1, 1'b1, 1'b0);
        drain();
        write_reg(wmfb_pkg::REG_KIND, DATA_W'(KIND_RSVD));
        add_item(8'h55, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h66, 1'b1, 1'b0, 1'b1, 1'b0);
        drain();
        write_reg(wmfb_pkg::REG_KIND, DATA_W'(wmfb_pkg::KIND_DATA));
        add_item(8'h77, 1'b1, 1'b0, 1'b1, 1'b0);
        drain();

        // Overlong payloads in data and ack mode; the flag clears on the next message
        set_frame_regs(wmfb_pkg::KIND_DATA, 16'($urandom), rand_addr(), rand_addr(),
                       rand_addr());
        queue_message(int'(wmfb_pkg::MAX_PAYLOAD) + 2, 1'b0);
        queue_message(2, 1'b0);
        drain();
        write_reg(wmfb_pkg::REG_KIND, DATA_W'(wmfb_pkg::KIND_ACK));
        queue_message(int'(wmfb_pkg::MAX_PAYLOAD) + 1, 1'b0);
        queue_message(1, 1'b0);
        drain();

        // Random traffic, the first phase with no idling on either side
        quiet_mode = 1'b1;
        run_random_phase(wmfb_pkg::KIND_DATA, 16'($urandom), rand_addr(), rand_addr(),
                         rand_addr(), 30);
        quiet_mode = 1'b0;
        run_random_phase(wmfb_pkg::KIND_DATA, 16'($urandom), rand_addr(), rand_addr(),
                         rand_addr(), 30);
        run_random_phase(wmfb_pkg::KIND_ACK, 16'($urandom), rand_addr(), rand_addr(),
                         rand_addr(), 25);
        run_random_phase(2'($urandom), 16'($urandom), rand_addr(), rand_addr(), rand_addr(),
                         20);
        run_random_phase(wmfb_pkg::KIND_DATA, 16'hFFFF, ADDR_ONES, '0, ADDR_ONES, 25);
        drain();

        $display("covered %0d input transactions over data, ack, management and reserved kinds",
                 items_sent);
        $display("checked %0d output bytes in %0d frames, overlong payloads included",
                 bytes_checked, frames_seen);
        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
